// ----- design/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the clipped histogram contrast stretch.
// ----------------------------------------------------------------------------
`default_nettype none

package hcs_pkg;

  localparam int LVL_BITS  = 8;
  localparam int LEVELS    = 256;
  localparam int THR_BITS  = 17;
  localparam int FRAC_BITS = 16;

  localparam logic [LVL_BITS-1:0] LVL_MAX = 8'd255;
  localparam logic [LVL_BITS-1:0] LVL_MIN = 8'd0;

  localparam logic KIND_HIST = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [LVL_BITS-1:0] pixel;
    logic                last;
  } in_word_t;

  typedef struct packed {
    logic [LVL_BITS-1:0] pixel_out;
    logic [LVL_BITS-1:0] low_level;
    logic [LVL_BITS-1:0] high_level;
    logic                last_out;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

// ----- design/histogram_clipped_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// histogram_clipped_contrast_stretch
// Two-pass contrast stretch: clipped histogram, level search, pixel mapping.
// Histogram words: one per cycle while idle; read-modify-write of the bin memory
//   with forwarding of the previous write. A last histogram word then runs a
//   drain state, a 256-entry scan of the bin memory and a closing state.
// Mapping words: one at a time, each held until the result of the 8-step
//   serial divider is taken. Reset clears counts, levels to 255/0, threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_clipped_contrast_stretch #(
  parameter int COUNT_BITS = 22
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire hcs_pkg::in_word_t            in_word,
  output logic                              out_valid,
  input  wire                               out_ready,
  output hcs_pkg::out_word_t                out_word,
  input  wire                               cfg_wr_en,
  input  wire [hcs_pkg::THR_BITS-1:0]       cfg_wr_data
);

  localparam int LB     = hcs_pkg::LVL_BITS;
  localparam int PROD_W = COUNT_BITS + hcs_pkg::THR_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  hcs_pkg::state_t state_r, state_nxt;

  logic [hcs_pkg::THR_BITS-1:0] thr_r;
  logic [COUNT_BITS-1:0]        total_r;
  logic                         h1_vld_r;
  logic [LB-1:0]                h1_addr_r;
  logic                         lw_vld_r;
  logic [LB-1:0]                lw_addr_r;
  logic [COUNT_BITS-1:0]        lw_data_r;
  logic [PROD_W-1:0]            prod_r;
  logic [LB-1:0]                scan_addr_r;
  logic                         scan_dv_r;
  logic [LB-1:0]                scan_lvl_r;
  logic                         found_r;
  logic [LB-1:0]                min_r;
  logic [LB-1:0]                max_r;
  logic                         map_last_r;
  logic                         out_valid_r;
  hcs_pkg::out_word_t           out_word_r;

  logic                  acc;
  logic                  acc_hist;
  logic                  acc_map;
  logic [LB-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic [PROD_W-1:0]     bin_scaled;
  logic                  qual;
  logic                  div_vld;
  logic [LB-1:0]         div_res;
  logic                  div_ack;
  logic                  clr;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      hcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_word.kind == hcs_pkg::KIND_HIST && in_word.last) begin
          state_nxt = hcs_pkg::ST_DRAIN;
        end else if (in_valid && in_word.kind == hcs_pkg::KIND_MAP) begin
          state_nxt = hcs_pkg::ST_DIV;
        end
      end
      hcs_pkg::ST_DRAIN: begin
        state_nxt = hcs_pkg::ST_SCAN;
      end
      hcs_pkg::ST_SCAN: begin
        if (scan_addr_r == hcs_pkg::LVL_MAX) begin
          state_nxt = hcs_pkg::ST_SCAN_END;
        end
      end
      hcs_pkg::ST_SCAN_END: begin
        state_nxt = hcs_pkg::ST_IDLE;
      end
      hcs_pkg::ST_DIV: begin
        if (div_ack) begin
          state_nxt = hcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    acc        = in_valid && in_ready;
    acc_hist   = acc && (in_word.kind == hcs_pkg::KIND_HIST);
    acc_map    = acc && (in_word.kind == hcs_pkg::KIND_MAP);
    rd_addr    = (state_r == hcs_pkg::ST_SCAN) ? scan_addr_r : in_word.pixel;
    cur        = (lw_vld_r && lw_addr_r == h1_addr_r) ? lw_data_r : rd_data;
    inc        = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
    bin_scaled = {1'b0, rd_data, {hcs_pkg::FRAC_BITS{1'b0}}};
    qual       = scan_dv_r && (rd_data != '0) && (bin_scaled >= prod_r);
    div_ack    = (state_r == hcs_pkg::ST_DIV) && div_vld && (!out_valid_r || out_ready);
    clr        = div_ack && map_last_r;
  end

  hcs_hist_mem #(
    .CNT_W (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (h1_vld_r),
    .wr_addr (h1_addr_r),
    .wr_data (inc),
    .rd_addr (rd_addr),
    .clr     (clr),
    .rd_data (rd_data)
  );

  hcs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (acc_map),
    .pixel   (in_word.pixel),
    .low     (min_r),
    .high    (max_r),
    .ack     (div_ack),
    .res_vld (div_vld),
    .res     (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcs_pkg::ST_IDLE;
      thr_r       <= '0;
      total_r     <= '0;
      h1_vld_r    <= 1'b0;
      lw_vld_r    <= 1'b0;
      scan_dv_r   <= 1'b0;
      found_r     <= 1'b0;
      min_r       <= hcs_pkg::LVL_MAX;
      max_r       <= hcs_pkg::LVL_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      h1_vld_r  <= acc_hist;
      lw_vld_r  <= h1_vld_r && !clr;
      scan_dv_r <= (state_r == hcs_pkg::ST_SCAN);
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (clr) begin
        total_r <= '0;
      end else if (acc_hist && total_r != CNT_MAX) begin
        total_r <= total_r + COUNT_BITS'(1);
      end
      if (state_r == hcs_pkg::ST_DRAIN) begin
        found_r <= 1'b0;
        min_r   <= hcs_pkg::LVL_MAX;
        max_r   <= hcs_pkg::LVL_MIN;
      end else if (qual) begin
        found_r <= 1'b1;
        max_r   <= scan_lvl_r;
        if (!found_r) begin
          min_r <= scan_lvl_r;
        end
      end
      if (div_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h1_addr_r  <= in_word.pixel;
    lw_addr_r  <= h1_addr_r;
    lw_data_r  <= inc;
    prod_r     <= PROD_W'(thr_r) * PROD_W'(total_r);
    scan_lvl_r <= scan_addr_r;
    if (state_r == hcs_pkg::ST_DRAIN) begin
      scan_addr_r <= '0;
    end else if (state_r == hcs_pkg::ST_SCAN) begin
      scan_addr_r <= scan_addr_r + LB'(1);
    end
    if (acc_map) begin
      map_last_r <= in_word.last;
    end
    if (div_ack) begin
      out_word_r.pixel_out  <= div_res;
      out_word_r.low_level  <= min_r;
      out_word_r.high_level <= max_r;
      out_word_r.last_out   <= map_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ----- design/hcs_hist_mem.sv -----
// ----------------------------------------------------------------------------
// hcs_hist_mem
// 256-bin histogram store, one write and one registered read per cycle.
// Per-bin valid flags make unwritten or cleared bins read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_hist_mem #(
  parameter int CNT_W = 22
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              wr_en,
  input  wire [hcs_pkg::LVL_BITS-1:0]      wr_addr,
  input  wire [CNT_W-1:0]                  wr_data,
  input  wire [hcs_pkg::LVL_BITS-1:0]      rd_addr,
  input  wire                              clr,
  output logic [CNT_W-1:0]                 rd_data
);

  logic [CNT_W-1:0]          mem_r [hcs_pkg::LEVELS];
  logic [hcs_pkg::LEVELS-1:0] vld_r;
  logic [CNT_W-1:0]          rd_data_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- design/hcs_div.sv -----
// ----------------------------------------------------------------------------
// hcs_div
// Stretch unit: ((p - low) * 255) / |high - low| with clamping, one quotient
// bit per cycle by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [hcs_pkg::LVL_BITS-1:0]  pixel,
  input  wire [hcs_pkg::LVL_BITS-1:0]  low,
  input  wire [hcs_pkg::LVL_BITS-1:0]  high,
  input  wire                          ack,
  output logic                         res_vld,
  output logic [hcs_pkg::LVL_BITS-1:0] res
);

  localparam int LB = hcs_pkg::LVL_BITS;

  logic          busy_r;
  logic [2:0]    cnt_r;
  logic          res_vld_r;
  logic [LB-1:0] rem_r;
  logic [LB-1:0] dq_r;
  logic [LB-1:0] d_r;
  logic          force_r;
  logic [LB-1:0] force_val_r;

  logic [LB-1:0]   span;
  logic [LB-1:0]   n;
  logic [2*LB-1:0] num;
  logic            frc;
  logic [LB-1:0]   frc_val;
  logic [LB:0]     trial;
  logic [LB:0]     diff;
  logic            ge;

  always_comb begin
    span    = (high >= low) ? (high - low) : (low - high);
    n       = pixel - low;
    num     = {n, {LB{1'b0}}} - {{LB{1'b0}}, n};
    frc     = 1'b0;
    frc_val = hcs_pkg::LVL_MIN;
    if (pixel <= low) begin
      frc     = 1'b1;
      frc_val = hcs_pkg::LVL_MIN;
    end else if (n >= span) begin
      // covers equal levels too: quotient at or above full scale
      frc     = 1'b1;
      frc_val = hcs_pkg::LVL_MAX;
    end
    trial = {rem_r, dq_r[LB-1]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r    <= 1'b0;
          res_vld_r <= 1'b1;
        end
      end
      if (ack) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r       <= num[2*LB-1:LB];
      dq_r        <= num[LB-1:0];
      d_r         <= span;
      force_r     <= frc;
      force_val_r <= frc_val;
    end else if (busy_r) begin
      rem_r <= ge ? diff[LB-1:0] : trial[LB-1:0];
      dq_r  <= {dq_r[LB-2:0], ge};
    end
  end

  assign res_vld = res_vld_r;
  assign res     = force_r ? force_val_r : dq_r;

endmodule

`default_nettype wire

// ----- design/hcs_checker.sv -----
// ----------------------------------------------------------------------------
// hcs_checker
// Port-level checks for the contrast stretch, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire hcs_pkg::in_word_t  in_word,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire hcs_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared without a mapping computation");

  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_word.kind == hcs_pkg::KIND_HIST && in_word.last
    |=> !in_ready)
    else $error("input taken during level search");

  a_flat_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.low_level == out_word.high_level
    |-> out_word.pixel_out == hcs_pkg::LVL_MIN || out_word.pixel_out == hcs_pkg::LVL_MAX)
    else $error("equal levels gave a mid-range pixel");

endmodule

bind histogram_clipped_contrast_stretch hcs_checker u_hcs_checker (.*);

`default_nettype wire
